[rtl/svi_pkg.sv]
// ----------------------------------------------------------------------------
// svi_pkg
// Shared types, widths and codes for the schema integer validator.
// ----------------------------------------------------------------------------
package svi_pkg;

    // Width in which values, bounds and the divisor are compared (8 to 64).
    localparam int VALUE_WIDTH = 64;
    localparam int REG_WIDTH   = 64;
    localparam int IDX_WIDTH   = 3;

    typedef enum logic [1:0] {
        KIND_INT    = 2'd0,
        KIND_DOUBLE = 2'd1,
        KIND_OTHER  = 2'd2,
        KIND_SPARE  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        VERDICT_VALID   = 2'd0,
        VERDICT_TYPE    = 2'd1,
        VERDICT_KEYWORD = 2'd2
    } t_verdict;

    typedef enum logic [2:0] {
        FAIL_NONE     = 3'd0,
        FAIL_TYPE     = 3'd1,
        FAIL_FRACTION = 3'd2,
        FAIL_MIN      = 3'd3,
        FAIL_EXCL_MIN = 3'd4,
        FAIL_MAX      = 3'd5,
        FAIL_EXCL_MAX = 3'd6,
        FAIL_MULTIPLE = 3'd7
    } t_fail_code;

    typedef enum logic [IDX_WIDTH-1:0] {
        REG_DRAFT_MODE     = 3'd0,
        REG_KEYWORD_MASK   = 3'd1,
        REG_MINIMUM        = 3'd2,
        REG_EXCLUSIVE_LOW  = 3'd3,
        REG_MAXIMUM        = 3'd4,
        REG_EXCLUSIVE_HIGH = 3'd5,
        REG_DIVISOR        = 3'd6,
        REG_UNUSED         = 3'd7
    } t_reg_index;

    // Keyword mask bit positions.
    localparam int KW_MIN      = 0;
    localparam int KW_EXCL_MIN = 1;
    localparam int KW_MAX      = 2;
    localparam int KW_EXCL_MAX = 3;
    localparam int KW_MULTIPLE = 4;

    // Configuration as seen by the check stage.
    typedef struct packed {
        logic                   draft6;
        logic [4:0]             kw_mask;
        logic [REG_WIDTH-1:0]   minimum;
        logic [REG_WIDTH-1:0]   excl_low;
        logic [REG_WIDTH-1:0]   maximum;
        logic [REG_WIDTH-1:0]   excl_high;
        logic [REG_WIDTH-1:0]   divisor;
    } t_cfg;

    // Request travelling through the remainder pipeline.
    typedef struct packed {
        logic                   valid;
        t_fail_code             code;
        logic                   need_mod;
        logic                   div_zero;
    } t_mod_ctl;

endpackage

[rtl/schema_integer_validator.sv]
// ----------------------------------------------------------------------------
// schema_integer_validator
// Checks JSON instances against integer schema keywords, one per cycle unless stalled.
// ----------------------------------------------------------------------------
// A request is accepted in every cycle in which the output side is not
// stalled, and its result passes through one decode stage, one
// bound-check stage, one remainder stage per value bit for multipleOf,
// and the output register.
// All stages advance together, so a stall on the output holds the whole
// pipeline and nothing is lost or repeated. Configuration registers are
// read live and must be written only while no request is in flight.
module schema_integer_validator
    import svi_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration write port.
    input  logic                 i_cfg_wr_en,
    input  logic [IDX_WIDTH-1:0] i_cfg_index,
    input  logic [REG_WIDTH-1:0] i_cfg_wdata,
    // Request stream.
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [127:0]         s_axis_tdata,  // [63:0] int_value, [127:64] double_bits
    input  logic [1:0]           s_axis_tuser,  // [1:0] value_kind
    // Result stream.
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [7:0]           m_axis_tdata   // [1:0] verdict, [4:2] fail_code, zeros
);

    t_cfg                   r_cfg;
    logic                   en;
    logic                   dec_valid;
    logic [VALUE_WIDTH-1:0] dec_value;
    t_fail_code             dec_code;
    t_mod_ctl               chk_ctl;
    logic [VALUE_WIDTH-1:0] chk_val_mag;
    logic [VALUE_WIDTH-1:0] chk_div_mag;
    logic                   mod_valid;
    t_fail_code             mod_code;
    logic                   r_out_valid;
    t_fail_code             r_out_code;
    t_verdict               out_verdict;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.draft6    <= 1'b1;
            r_cfg.kw_mask   <= '0;
            r_cfg.minimum   <= '0;
            r_cfg.excl_low  <= '0;
            r_cfg.maximum   <= '0;
            r_cfg.excl_high <= '0;
            r_cfg.divisor   <= REG_WIDTH'(1);
        end else if (i_cfg_wr_en) begin
            case (t_reg_index'(i_cfg_index))
                REG_DRAFT_MODE:     r_cfg.draft6    <= i_cfg_wdata[0];
                REG_KEYWORD_MASK:   r_cfg.kw_mask   <= i_cfg_wdata[4:0];
                REG_MINIMUM:        r_cfg.minimum   <= i_cfg_wdata;
                REG_EXCLUSIVE_LOW:  r_cfg.excl_low  <= i_cfg_wdata;
                REG_MAXIMUM:        r_cfg.maximum   <= i_cfg_wdata;
                REG_EXCLUSIVE_HIGH: r_cfg.excl_high <= i_cfg_wdata;
                REG_DIVISOR:        r_cfg.divisor   <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Pipeline advances whenever the output register can take a result.
    assign en            = !r_out_valid || m_axis_tready;
    assign s_axis_tready = en;

    svi_decode u_decode (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (en),
        .i_valid       (s_axis_tvalid),
        .i_kind        (s_axis_tuser),
        .i_int_value   (s_axis_tdata[63:0]),
        .i_double_bits (s_axis_tdata[127:64]),
        .o_valid       (dec_valid),
        .o_value       (dec_value),
        .o_code        (dec_code)
    );

    svi_check u_check (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_cfg     (r_cfg),
        .i_valid   (dec_valid),
        .i_value   (dec_value),
        .i_code    (dec_code),
        .o_ctl     (chk_ctl),
        .o_val_mag (chk_val_mag),
        .o_div_mag (chk_div_mag)
    );

    svi_mod_pipe u_mod_pipe (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_ctl     (chk_ctl),
        .i_val_mag (chk_val_mag),
        .i_div_mag (chk_div_mag),
        .o_valid   (mod_valid),
        .o_code    (mod_code)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= mod_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_code <= mod_code;
        end
    end

    // Verdict follows from the failure code.
    always_comb begin
        case (r_out_code)
            FAIL_NONE:     out_verdict = VERDICT_VALID;
            FAIL_TYPE:     out_verdict = VERDICT_TYPE;
            FAIL_FRACTION: out_verdict = VERDICT_TYPE;
            default:       out_verdict = VERDICT_KEYWORD;
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out_code, out_verdict};

endmodule

[rtl/svi_decode.sv]
// ----------------------------------------------------------------------------
// svi_decode
// First stage: turns the instance into a signed value, converting doubles
// to integers with saturation and flagging type and fraction failures.
// ----------------------------------------------------------------------------
module svi_decode
    import svi_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic [1:0]             i_kind,
    input  logic [63:0]            i_int_value,
    input  logic [63:0]            i_double_bits,
    output logic                   o_valid,
    output logic [VALUE_WIDTH-1:0] o_value,
    output t_fail_code             o_code
);

    localparam logic [VALUE_WIDTH-1:0] MAXV = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic [VALUE_WIDTH-1:0] MINV = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    localparam logic [10:0] EXP_BIAS = 11'd1023;
    localparam logic [10:0] EXP_SAT  = 11'(1023 + VALUE_WIDTH - 1);

    logic                   r_valid;
    logic [VALUE_WIDTH-1:0] r_value;
    t_fail_code             r_code;
    logic [VALUE_WIDTH-1:0] n_value;
    t_fail_code             n_code;

    logic                   neg;
    logic [10:0]            expo;
    logic [51:0]            mant;
    logic [52:0]            sig;
    logic [10:0]            ex;
    logic [5:0]             rsh;
    logic [5:0]             lsh;
    logic [52:0]            frac_mask;
    logic [63:0]            mag;
    logic [VALUE_WIDTH-1:0] dval;
    logic                   dfail;

    // Double to integer conversion.
    always_comb begin
        neg       = i_double_bits[63];
        expo      = i_double_bits[62:52];
        mant      = i_double_bits[51:0];
        sig       = {1'b1, mant};
        ex        = expo - EXP_BIAS;
        rsh       = 6'(11'd52 - ex);
        lsh       = 6'(ex - 11'd52);
        frac_mask = ~({53{1'b1}} << rsh);
        mag       = (ex < 11'd52) ? 64'(sig >> rsh) : (64'(sig) << lsh);
        dfail     = 1'b0;
        dval      = '0;
        if (expo == 11'h7FF) begin
            dfail = (mant != '0);
            dval  = neg ? MINV : MAXV;
        end else if (expo == 11'd0) begin
            dfail = (mant != '0);
        end else if (expo < EXP_BIAS) begin
            dfail = 1'b1;
        end else if (ex < 11'd52 && (sig & frac_mask) != '0) begin
            dfail = 1'b1;
        end else if (expo >= EXP_SAT) begin
            dval = neg ? MINV : MAXV;
        end else begin
            dval = neg ? VALUE_WIDTH'(64'd0 - mag) : mag[VALUE_WIDTH-1:0];
        end
    end

    // Selection by kind.
    always_comb begin
        n_value = i_int_value[VALUE_WIDTH-1:0];
        n_code  = FAIL_NONE;
        case (t_kind'(i_kind))
            KIND_INT: begin
                n_value = i_int_value[VALUE_WIDTH-1:0];
            end
            KIND_DOUBLE: begin
                n_value = dval;
                n_code  = dfail ? FAIL_FRACTION : FAIL_NONE;
            end
            default: begin
                n_code = FAIL_TYPE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_value <= n_value;
            r_code  <= n_code;
        end
    end

    assign o_valid = r_valid;
    assign o_value = r_value;
    assign o_code  = r_code;

endmodule

[rtl/svi_check.sv]
// ----------------------------------------------------------------------------
// svi_check
// Second stage: applies the bound keywords in order and prepares the
// magnitudes for the multipleOf remainder.
// ----------------------------------------------------------------------------
module svi_check
    import svi_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  t_cfg                   i_cfg,
    input  logic                   i_valid,
    input  logic [VALUE_WIDTH-1:0] i_value,
    input  t_fail_code             i_code,
    output t_mod_ctl               o_ctl,
    output logic [VALUE_WIDTH-1:0] o_val_mag,
    output logic [VALUE_WIDTH-1:0] o_div_mag
);

    logic signed [VALUE_WIDTH-1:0] v;
    logic signed [VALUE_WIDTH-1:0] mn;
    logic signed [VALUE_WIDTH-1:0] xl;
    logic signed [VALUE_WIDTH-1:0] mx;
    logic signed [VALUE_WIDTH-1:0] xh;
    logic        [VALUE_WIDTH-1:0] d;
    t_fail_code                    n_code;
    logic [VALUE_WIDTH-1:0]        n_val_mag;
    logic [VALUE_WIDTH-1:0]        n_div_mag;

    t_mod_ctl               r_ctl;
    logic [VALUE_WIDTH-1:0] r_val_mag;
    logic [VALUE_WIDTH-1:0] r_div_mag;

    // Ordered bound checks.
    always_comb begin
        v      = i_value;
        mn     = i_cfg.minimum[VALUE_WIDTH-1:0];
        xl     = i_cfg.excl_low[VALUE_WIDTH-1:0];
        mx     = i_cfg.maximum[VALUE_WIDTH-1:0];
        xh     = i_cfg.excl_high[VALUE_WIDTH-1:0];
        d      = i_cfg.divisor[VALUE_WIDTH-1:0];
        n_code = i_code;
        if (i_code == FAIL_NONE) begin
            if (i_cfg.draft6) begin
                if (i_cfg.kw_mask[KW_MIN] && v < mn) begin
                    n_code = FAIL_MIN;
                end else if (i_cfg.kw_mask[KW_EXCL_MIN] && !(xl < v)) begin
                    n_code = FAIL_EXCL_MIN;
                end else if (i_cfg.kw_mask[KW_MAX] && mx < v) begin
                    n_code = FAIL_MAX;
                end else if (i_cfg.kw_mask[KW_EXCL_MAX] && !(v < xh)) begin
                    n_code = FAIL_EXCL_MAX;
                end
            end else begin
                if (i_cfg.kw_mask[KW_MIN] && v < mn) begin
                    n_code = FAIL_MIN;
                end else if (i_cfg.kw_mask[KW_MIN] && i_cfg.kw_mask[KW_EXCL_MIN]
                             && i_cfg.excl_low != '0 && v == mn) begin
                    n_code = FAIL_EXCL_MIN;
                end else if (i_cfg.kw_mask[KW_MAX] && mx < v) begin
                    n_code = FAIL_MAX;
                end else if (i_cfg.kw_mask[KW_MAX] && i_cfg.kw_mask[KW_EXCL_MAX]
                             && i_cfg.excl_high != '0 && v == mx) begin
                    n_code = FAIL_EXCL_MAX;
                end
            end
        end
        n_val_mag = v[VALUE_WIDTH-1] ? (~i_value + 1'b1) : i_value;
        n_div_mag = d[VALUE_WIDTH-1] ? (~d + 1'b1) : d;
    end

    // Stage register: only the valid bit is reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else if (i_en) begin
            r_ctl.valid <= i_valid;
        end
        if (i_en) begin
            r_ctl.code     <= n_code;
            r_ctl.need_mod <= i_cfg.kw_mask[KW_MULTIPLE] && (n_code == FAIL_NONE);
            r_ctl.div_zero <= (n_div_mag == '0);
            r_val_mag      <= n_val_mag;
            r_div_mag      <= n_div_mag;
        end
    end

    assign o_ctl     = r_ctl;
    assign o_val_mag = r_val_mag;
    assign o_div_mag = r_div_mag;

endmodule

[rtl/svi_mod_pipe.sv]
// ----------------------------------------------------------------------------
// svi_mod_pipe
// Restoring remainder pipeline: one quotient bit per register stage,
// VALUE_WIDTH stages, then the final multipleOf decision.
// ----------------------------------------------------------------------------
module svi_mod_pipe
    import svi_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  t_mod_ctl               i_ctl,
    input  logic [VALUE_WIDTH-1:0] i_val_mag,
    input  logic [VALUE_WIDTH-1:0] i_div_mag,
    output logic                   o_valid,
    output t_fail_code             o_code
);

    localparam int W = VALUE_WIDTH;

    t_mod_ctl       r_ctl  [W];
    logic [W-1:0]   r_rem  [W];
    logic [W-1:0]   r_num  [W];
    logic [W-1:0]   r_den  [W];

    for (genvar g = 0; g < W; g++) begin : g_step
        t_mod_ctl     s_ctl;
        logic [W-1:0] s_rem;
        logic [W-1:0] s_num;
        logic [W-1:0] s_den;
        logic [W:0]   trial;
        logic [W:0]   diff;
        logic [W-1:0] n_rem;

        // The first stage takes the incoming request, later ones the stage before.
        if (g == 0) begin : g_first
            assign s_ctl = i_ctl;
            assign s_rem = '0;
            assign s_num = i_val_mag;
            assign s_den = i_div_mag;
        end else begin : g_next
            assign s_ctl = r_ctl[g-1];
            assign s_rem = r_rem[g-1];
            assign s_num = r_num[g-1];
            assign s_den = r_den[g-1];
        end

        // Bring down the next dividend bit and subtract when it fits.
        always_comb begin
            trial = {s_rem, s_num[W-1]};
            diff  = trial - {1'b0, s_den};
            n_rem = diff[W] ? trial[W-1:0] : diff[W-1:0];
        end

        // Stage register: only the valid bit is reset.
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[g].valid <= 1'b0;
            end else if (i_en) begin
                r_ctl[g].valid <= s_ctl.valid;
            end
            if (i_en) begin
                r_ctl[g].code     <= s_ctl.code;
                r_ctl[g].need_mod <= s_ctl.need_mod;
                r_ctl[g].div_zero <= s_ctl.div_zero;
                r_rem[g]          <= n_rem;
                r_num[g]          <= s_num << 1;
                r_den[g]          <= s_den;
            end
        end
    end

    // Final decision on the remainder.
    always_comb begin
        o_valid = r_ctl[W-1].valid;
        o_code  = r_ctl[W-1].code;
        if (r_ctl[W-1].need_mod && (r_ctl[W-1].div_zero || r_rem[W-1] != '0)) begin
            o_code = FAIL_MULTIPLE;
        end
    end

endmodule

[tb/tb_schema_integer_validator.sv]
// ----------------------------------------------------------------------------
// tb_schema_integer_validator
// Self-checking testbench for the schema integer validator. Named tests
// program the keyword registers, stream JSON instances into the request
// port and compare every verdict and failure code with a local prediction.
// ----------------------------------------------------------------------------
module tb_schema_integer_validator;
    import svi_pkg::*;

    localparam int    LATENCY     = VALUE_WIDTH + 3;
    localparam int    CYCLE_LIMIT = 400000;
    localparam logic signed [63:0] INT64_MIN = 64'sh8000_0000_0000_0000;
    localparam logic signed [63:0] INT64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        t_verdict   verdict;
        t_fail_code code;
    } t_outcome;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_wr_en;
    logic [IDX_WIDTH-1:0] i_cfg_index;
    logic [REG_WIDTH-1:0] i_cfg_wdata;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [127:0]         s_axis_tdata;   // [63:0] int_value, [127:64] double_bits
    logic [1:0]           s_axis_tuser;   // [1:0] value_kind
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [7:0]           m_axis_tdata;   // [1:0] verdict, [4:2] fail_code, zeros

    // Local copy of the keyword registers.
    logic                    draft6;
    logic [4:0]              kw_mask;
    logic signed [63:0]      min_bound, excl_low, max_bound, excl_high, div_value;

    t_outcome outcome_q[$];
    int       error_count;
    int       cycle_count;
    int       send_idle_pct;
    int       recv_idle_pct;
    int       hold_request;
    int       hold_left;

    schema_integer_validator DUT (.*);

    // Clock generation.
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Converts raw double bits to an integer; returns 0 for NaN or a fraction.
    function automatic bit double_to_integer(input logic [63:0] bits,
                                             output logic signed [63:0] value);
        logic        neg;
        logic [10:0] expo;
        logic [63:0] sig;
        logic [63:0] mag;
        int          ex;
        neg  = bits[63];
        expo = bits[62:52];
        sig  = {11'd0, 1'b1, bits[51:0]};
        value = 64'sd0;
        if (expo == 11'h7FF) begin
            if (bits[51:0] != 52'd0) return 1'b0;
            value = neg ? INT64_MIN : INT64_MAX;
            return 1'b1;
        end
        if (expo == 11'd0) return (bits[51:0] == 52'd0);
        if (expo < 11'd1023) return 1'b0;
        ex = int'(expo) - 1023;
        if (ex < 52 && (sig & ((64'd1 << (52 - ex)) - 64'd1)) != 64'd0) return 1'b0;
        if (ex >= 63) begin
            value = neg ? INT64_MIN : INT64_MAX;
            return 1'b1;
        end
        mag = (ex < 52) ? (sig >> (52 - ex)) : (sig << (ex - 52));
        value = neg ? -$signed(mag) : $signed(mag);
        return 1'b1;
    endfunction

    function automatic logic [63:0] abs_value(input logic signed [63:0] v);
        return v[63] ? -v : v;
    endfunction

    // Predicts the verdict for one instance under the current keywords.
    function automatic t_outcome predict_outcome(input t_kind kind,
                                                 input logic signed [63:0] ival,
                                                 input logic [63:0] dbits);
        logic signed [63:0] v;
        logic [63:0]        dm;
        if (kind == KIND_INT) begin
            v = ival;
        end else if (kind == KIND_DOUBLE) begin
            if (!double_to_integer(dbits, v)) return '{VERDICT_TYPE, FAIL_FRACTION};
        end else begin
            return '{VERDICT_TYPE, FAIL_TYPE};
        end
        if (draft6) begin
            if (kw_mask[KW_MIN] && v < min_bound) return '{VERDICT_KEYWORD, FAIL_MIN};
            if (kw_mask[KW_EXCL_MIN] && !(excl_low < v))
                return '{VERDICT_KEYWORD, FAIL_EXCL_MIN};
            if (kw_mask[KW_MAX] && max_bound < v) return '{VERDICT_KEYWORD, FAIL_MAX};
            if (kw_mask[KW_EXCL_MAX] && !(v < excl_high))
                return '{VERDICT_KEYWORD, FAIL_EXCL_MAX};
        end else begin
            if (kw_mask[KW_MIN]) begin
                if (v < min_bound) return '{VERDICT_KEYWORD, FAIL_MIN};
                if (kw_mask[KW_EXCL_MIN] && excl_low != 0 && v == min_bound)
                    return '{VERDICT_KEYWORD, FAIL_EXCL_MIN};
            end
            if (kw_mask[KW_MAX]) begin
                if (max_bound < v) return '{VERDICT_KEYWORD, FAIL_MAX};
                if (kw_mask[KW_EXCL_MAX] && excl_high != 0 && v == max_bound)
                    return '{VERDICT_KEYWORD, FAIL_EXCL_MAX};
            end
        end
        if (kw_mask[KW_MULTIPLE]) begin
            dm = abs_value(div_value);
            if (dm == 64'd0 || abs_value(v) % dm != 64'd0)
                return '{VERDICT_KEYWORD, FAIL_MULTIPLE};
        end
        return '{VERDICT_VALID, FAIL_NONE};
    endfunction

    // Result side: checks each accepted result and decides the next tready.
    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (outcome_q.size() == 0) begin
                $display("%0t: unexpected result verdict=%0d code=%0d", $time,
                         m_axis_tdata[1:0], m_axis_tdata[4:2]);
                error_count++;
            end else begin
                want = outcome_q.pop_front();
                if (m_axis_tdata[1:0] !== want.verdict) begin
                    $display("%0t: verdict mismatch expected=%0d actual=%0d", $time,
                             want.verdict, m_axis_tdata[1:0]);
                    error_count++;
                end
                if (m_axis_tdata[4:2] !== want.code) begin
                    $display("%0t: fail_code mismatch expected=%0d actual=%0d", $time,
                             want.code, m_axis_tdata[4:2]);
                    error_count++;
                end
            end
        end
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offers one request, idling at random first, and waits until it is taken.
    task automatic send_value(input t_kind kind, input logic signed [63:0] ival,
                              input logic [63:0] dbits);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {dbits, ival};
        do @(posedge i_clk); while (!s_axis_tready);
        outcome_q.push_back(predict_outcome(kind, ival, dbits));
    endtask

    task automatic send_int(input logic signed [63:0] ival);
        send_value(KIND_INT, ival, {$urandom, $urandom});
    endtask

    task automatic send_double(input logic [63:0] dbits);
        send_value(KIND_DOUBLE, {$urandom, $urandom}, dbits);
    endtask

    // Stops sending and waits until every result is back and the pipe is empty.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (outcome_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // Writes one register and mirrors it in the local copy.
    task automatic write_reg(input t_reg_index idx, input logic [63:0] value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            REG_DRAFT_MODE:     draft6    = value[0];
            REG_KEYWORD_MASK:   kw_mask   = value[4:0];
            REG_MINIMUM:        min_bound = value;
            REG_EXCLUSIVE_LOW:  excl_low  = value;
            REG_MAXIMUM:        max_bound = value;
            REG_EXCLUSIVE_HIGH: excl_high = value;
            REG_DIVISOR:        div_value = value;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic write_keywords(input logic d6, input logic [4:0] mask,
                                  input logic signed [63:0] mn, input logic signed [63:0] xl,
                                  input logic signed [63:0] mx, input logic signed [63:0] xh,
                                  input logic signed [63:0] dv);
        write_reg(REG_DRAFT_MODE, {$urandom, $urandom} & ~64'd1 | 64'(d6));
        write_reg(REG_KEYWORD_MASK, {$urandom, $urandom} & ~64'd31 | 64'(mask));
        write_reg(REG_MINIMUM, mn);
        write_reg(REG_EXCLUSIVE_LOW, xl);
        write_reg(REG_MAXIMUM, mx);
        write_reg(REG_EXCLUSIVE_HIGH, xh);
        write_reg(REG_DIVISOR, dv);
    endtask

    // Draws a bound: mostly small, sometimes full width or an extreme.
    function automatic logic signed [63:0] pick_bound();
        case ($urandom_range(5))
            0:       return {$urandom, $urandom};
            1:       return $urandom_range(1) ? INT64_MIN : INT64_MAX;
            default: return 64'sd50 - 64'($urandom_range(100));
        endcase
    endfunction

    function automatic logic signed [63:0] pick_divisor();
        case ($urandom_range(7))
            0:       return 64'sd0;
            1:       return -64'sd1;
            2:       return INT64_MIN;
            3:       return {$urandom, $urandom};
            4:       return -64'sd2 - 64'($urandom_range(7));
            default: return 64'sd1 + 64'($urandom_range(8));
        endcase
    endfunction

    // Integer instance aimed at the bounds so that every check is exercised.
    function automatic logic signed [63:0] pick_instance();
        logic signed [63:0] anchor;
        case ($urandom_range(3))
            0: anchor = min_bound;
            1: anchor = excl_low;
            2: anchor = max_bound;
            default: anchor = excl_high;
        endcase
        case ($urandom_range(7))
            0, 1:    return {$urandom, $urandom};
            2:       return 64'sd30 - 64'($urandom_range(60));
            default: return anchor + 64'($urandom_range(4)) - 64'sd2;
        endcase
    endfunction

    task automatic send_random_item();
        logic signed [63:0] v;
        int                 pick;
        pick = $urandom_range(99);
        v    = pick_instance();
        if (pick < 45) begin
            send_int(v);
        end else if (pick < 85) begin
            case ($urandom_range(9))
                0, 1, 2, 3: send_double($realtobits(real'(v)));
                4, 5:       send_double($realtobits(real'(v % 1000) + 0.5));
                6, 7:       send_double({$urandom, $urandom});
                8:          send_double({1'($urandom_range(1)), 11'h7FF,
                                         $urandom_range(1) ? 52'd0 : 52'({$urandom, $urandom})});
                default:    send_double({1'($urandom_range(1)),
                                         11'h43E + 11'($urandom_range(40)),
                                         52'({$urandom, $urandom})});
            endcase
        end else begin
            send_value($urandom_range(1) ? KIND_OTHER : KIND_SPARE,
                       {$urandom, $urandom}, {$urandom, $urandom});
        end
    endtask

    // Reset values: draft 6, no keywords, so only type checks apply.
    task automatic test_reset_defaults();
        send_int(INT64_MIN);
        send_double(64'h3FF0_0000_0000_0000);
        send_value(KIND_OTHER, INT64_MAX, 64'hFFFF_FFFF_FFFF_FFFF);
        send_value(KIND_SPARE, 64'sd0, 64'd0);
        drain_results();
    endtask

    // NaN, infinities, negative zero, subnormals, fractions and saturation.
    task automatic test_double_conversion();
        write_keywords(1'b1, 5'b00101, -64'sd3, 64'sd0, 64'sd3, 64'sd0, 64'sd1);
        send_double(64'h7FF8_0000_0000_0001);
        send_double(64'h7FF0_0000_0000_0000);
        send_double(64'hFFF0_0000_0000_0000);
        send_double(64'h8000_0000_0000_0000);
        send_double(64'h0000_0000_0000_0001);
        send_double(64'h3FE0_0000_0000_0000);
        send_double(64'h43E0_0000_0000_0000);
        drain_results();
    endtask

    // Draft 6 numeric bounds, each check failing once in order.
    task automatic test_draft6_bounds();
        write_keywords(1'b1, 5'b11111, -64'sd10, -64'sd5, 64'sd10, 64'sd5, 64'sd3);
        send_int(-64'sd11);
        send_int(-64'sd5);
        send_int(64'sd11);
        send_int(64'sd5);
        send_int(64'sd4);
        send_int(64'sd3);
        drain_results();
    endtask

    // Draft 4 boolean exclusives, also an exclusive flag without its bound.
    task automatic test_draft4_flags();
        write_keywords(1'b0, 5'b01111, -64'sd10, 64'sd1, 64'sd10, -64'sd1, 64'sd1);
        send_int(-64'sd10);
        send_int(64'sd10);
        send_int(64'sd0);
        drain_results();
        write_reg(REG_KEYWORD_MASK, 64'(1 << KW_EXCL_MIN));
        send_int(-64'sd10);
        drain_results();
    endtask

    // Zero divisor, and the most negative value with divisors minus one and itself.
    task automatic test_divisor_cases();
        write_keywords(1'b1, 5'b10000, INT64_MIN, INT64_MIN, INT64_MAX, INT64_MAX, 64'sd0);
        send_int(64'sd7);
        drain_results();
        write_reg(REG_DIVISOR, -64'sd1);
        send_int(INT64_MIN);
        drain_results();
        write_reg(REG_DIVISOR, INT64_MIN);
        send_int(INT64_MIN);
        drain_results();
    endtask

    // Random keywords and instances under one idling pattern.
    task automatic test_random_phase(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (3) begin
            write_keywords(1'($urandom_range(1)), 5'($urandom_range(31)), pick_bound(),
                           pick_bound(), pick_bound(), pick_bound(), pick_divisor());
            repeat (110) send_random_item();
            drain_results();
        end
    endtask

    // The receiver stalls for a long stretch while requests keep coming.
    task automatic test_output_stall();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_keywords(1'b1, 5'b11111, -64'sd40, -64'sd41, 64'sd40, 64'sd41, 64'sd2);
        hold_request = 400;
        repeat (150) send_random_item();
        drain_results();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_index   = REG_DRAFT_MODE;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = KIND_INT;
        m_axis_tready = 1'b0;
        error_count   = 0;
        cycle_count   = 0;
        send_idle_pct = 13;
        recv_idle_pct = 48;
        hold_request  = 0;
        hold_left     = 0;
        draft6        = 1'b1;
        kw_mask       = 5'd0;
        min_bound     = 64'sd0;
        excl_low      = 64'sd0;
        max_bound     = 64'sd0;
        excl_high     = 64'sd0;
        div_value     = 64'sd1;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_double_conversion();
        test_draft6_bounds();
        test_draft4_flags();
        test_divisor_cases();
        test_random_phase(13, 48);
        test_random_phase(48, 13);
        test_random_phase(0, 0);
        test_output_stall();

        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
